// ----- sv/nnrs_pkg.sv -----
// Package for the nearest-neighbor raster scaler.
// Holds sizes, register index codes, item kinds, the sequencer state type and divider structs.
// No dependencies.
package nnrs_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int PIXEL_BITS     = 32;

   // store address is {row, col}
   localparam int COL_BITS  = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_SRC_HEIGHT);
   localparam int ADDR_BITS = COL_BITS + ROW_BITS;

   localparam int COORD_BITS     = 12;
   localparam int CSR_SRC_BITS   = 9;
   localparam int CSR_DST_BITS   = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;
   localparam int RSP_PIXEL_BITS = 32;

   // divider: num = (2d+1)*s, den = 2n, quotient < s < 2^CSR_SRC_BITS
   localparam int NUM_BITS  = CSR_DST_BITS + CSR_SRC_BITS;
   localparam int DEN_BITS  = CSR_DST_BITS + 1;
   localparam int QUOT_BITS = CSR_SRC_BITS;
   localparam int REM_BITS  = DEN_BITS;
   localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } nnrs_csr_type;

   typedef enum logic {
      ITEM_WRITE = 1'b0,
      ITEM_READ  = 1'b1
   } nnrs_item_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_MEM,
      ST_DONE,
      ST_ERR
   } nnrs_state_type;

   typedef struct packed {
      logic start;
   } nnrs_div_ctl_type;

   typedef struct packed {
      logic busy;
   } nnrs_div_stat_type;

endpackage

// ----- sv/nnrs_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nnrs_pkg; the quotient must fit in QUOT_BITS bits.
module nnrs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  nnrs_pkg::nnrs_div_ctl_type      ctl,
   input  logic [nnrs_pkg::NUM_BITS-1:0]   num,
   input  logic [nnrs_pkg::DEN_BITS-1:0]   den,
   output nnrs_pkg::nnrs_div_stat_type     stat,
   output logic [nnrs_pkg::QUOT_BITS-1:0]  quot
);
   import nnrs_pkg::*;

   logic                 busy_ff, busy_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [QUOT_BITS-1:0] low_ff, low_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;
   logic [REM_BITS:0]    trial;
   logic                 fits;

   assign trial = {rem_ff, low_ff[QUOT_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         // top bits start out below the divisor since the quotient is narrow
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(QUOT_BITS);
         rem_in  = REM_BITS'(num >> QUOT_BITS);
         low_in  = num[QUOT_BITS-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? REM_BITS'(trial - {1'b0, den_ff}) : REM_BITS'(trial);
         low_in  = {low_ff[QUOT_BITS-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign stat.busy = busy_ff;
   assign quot      = quot_ff;

endmodule

// ----- sv/nearest_neighbor_raster_scaler.sv -----
// Nearest-neighbor raster scaler: top level with source store and sequencer.
// Depends on nnrs_pkg and nnrs_div.
//
// A write item (kind 0) stores its pixel when it lies inside the source size; it gives
// no result, and the sequencer stays idle. A read item (kind 1) inside the destination
// size passes, from acceptance to a loaded result, through the (2x+1)*size products,
// the two bit-serial dividers that run side by side (one quotient bit per cycle), the
// registered store read, the memory state and the load of the output register; the
// next item is taken once the result is loaded. A read outside the destination size
// goes to the error state and from there loads error 1 into the output register; the
// next item is taken once the error is loaded. A read that finds the output register
// still full waits until the held result is taken.
// The block takes one item at a time; the next item is accepted while a result still
// waits in the output register. The store holds no reset value and needs no clearing
// pass; reading a pixel that was never written returns unspecified bits.
module nearest_neighbor_raster_scaler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [nnrs_pkg::COORD_BITS-1:0]      req_col,
   input  logic [nnrs_pkg::COORD_BITS-1:0]      req_row,
   input  logic [nnrs_pkg::PIXEL_BITS-1:0]      req_pixel_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [nnrs_pkg::RSP_PIXEL_BITS-1:0]  rsp_pixel_out,
   output logic                                 rsp_error,
   input  logic                                 csr_we,
   input  logic [nnrs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [nnrs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import nnrs_pkg::*;

   logic [CSR_SRC_BITS-1:0] src_width_ff, src_height_ff;
   logic [CSR_DST_BITS-1:0] dst_width_ff, dst_height_ff;
   logic [CSR_SRC_BITS-1:0] sw_eff, sh_eff;

   nnrs_state_type state_ff, state_in;

   logic [COORD_BITS-1:0]     col_ff, row_ff;
   logic [PIXEL_BITS-1:0]     store [2**ADDR_BITS];
   logic [PIXEL_BITS-1:0]     rd_data_ff;
   logic                      store_we;
   logic [ADDR_BITS-1:0]      wr_addr, rd_addr;

   logic                      accept, is_write, in_src, in_dst;
   logic                      out_free, load_ok, load_err, div_go;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_PIXEL_BITS-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                      rsp_error_ff, rsp_error_in;

   nnrs_div_ctl_type          div_ctl;
   nnrs_div_stat_type         div_x_stat, div_y_stat;
   logic [NUM_BITS-1:0]       num_x, num_y;
   logic [QUOT_BITS-1:0]      quot_x, quot_y;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= CSR_SRC_BITS'(256);
         src_height_ff <= CSR_SRC_BITS'(256);
         dst_width_ff  <= CSR_DST_BITS'(256);
         dst_height_ff <= CSR_DST_BITS'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[CSR_SRC_BITS-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[CSR_SRC_BITS-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[CSR_DST_BITS-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[CSR_DST_BITS-1:0];
            default: ;
         endcase
      end
   end

   // saturate source size to the store dimensions
   assign sw_eff = (src_width_ff > MAX_SRC_WIDTH) ?
                   CSR_SRC_BITS'(MAX_SRC_WIDTH) : src_width_ff;
   assign sh_eff = (src_height_ff > MAX_SRC_HEIGHT) ?
                   CSR_SRC_BITS'(MAX_SRC_HEIGHT) : src_height_ff;

   assign accept   = req_valid && req_ready;
   assign is_write = (req_kind == ITEM_WRITE);
   assign in_src   = (req_col < COORD_BITS'(sw_eff)) && (req_row < COORD_BITS'(sh_eff));
   assign in_dst   = ({1'b0, req_col} < dst_width_ff) && ({1'b0, req_row} < dst_height_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !is_write) begin
               state_in = in_dst ? ST_MUL : ST_ERR;
            end
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (!div_x_stat.busy && !div_y_stat.busy) begin
               state_in = ST_MEM;
            end
         end
         ST_MEM: state_in = ST_DONE;
         ST_DONE, ST_ERR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_go    = 1'b0;
      load_ok   = 1'b0;
      load_err  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MUL:  div_go    = 1'b1;
         ST_DIV, ST_MEM: ;
         ST_DONE: load_ok   = out_free;
         ST_ERR:  load_err  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the coordinate of each accepted item; for a read it is the destination coordinate
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= req_col;
         row_ff <= req_row;
      end
   end

   assign num_x = NUM_BITS'({col_ff, 1'b1}) * NUM_BITS'(sw_eff);
   assign num_y = NUM_BITS'({row_ff, 1'b1}) * NUM_BITS'(sh_eff);
   assign div_ctl.start = div_go;

   nnrs_div u_div_x (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (num_x),
      .den   ({dst_width_ff, 1'b0}),
      .stat  (div_x_stat),
      .quot  (quot_x)
   );

   nnrs_div u_div_y (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (num_y),
      .den   ({dst_height_ff, 1'b0}),
      .stat  (div_y_stat),
      .quot  (quot_y)
   );

   // source store: one write port, one registered read port
   assign store_we = accept && is_write && in_src;
   assign wr_addr  = {req_row[ROW_BITS-1:0], req_col[COL_BITS-1:0]};
   assign rd_addr  = {ROW_BITS'(quot_y), COL_BITS'(quot_x)};

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[wr_addr] <= req_pixel_in;
      end
      rd_data_ff <= store[rd_addr];
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_error_in = rsp_error_ff;
      if (load_ok) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = RSP_PIXEL_BITS'(rd_data_ff);
         rsp_error_in = 1'b0;
      end else if (load_err) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = '0;
         rsp_error_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_error     = rsp_error_ff;

`ifndef SYNTHESIS
   a_div_started : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (div_x_stat.busy && div_y_stat.busy))
      else $error("dividers not started after product stage");

   a_idle_div : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!div_x_stat.busy && !div_y_stat.busy))
      else $error("item accepted while a division runs");

   a_load_src : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE || $past(state_ff) == ST_ERR))
      else $error("result loaded outside a result state");
`endif

endmodule
